// ===== rtl/mg3_pkg.sv =====
// Shared types and constants for the 3x3 morphological gradient core.
`default_nettype none
package mg3_pkg;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: top row, middle row, bottom (newest) row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/mg3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mg3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mg3_col_cell.sv =====
// One window column cell: holds three pixels, shifts to its neighbor, reports its max.
`default_nettype none
module mg3_col_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire mg3_pkg::col_t col_in,
  output mg3_pkg::col_t      col_out,
  output mg3_pkg::pix_t      col_max
);

  mg3_pkg::col_t col_r;
  mg3_pkg::pix_t tm_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
  assign tm_max  = (col_r.top > col_r.mid) ? col_r.top : col_r.mid;
  assign col_max = (tm_max > col_r.bot) ? tm_max : col_r.bot;

endmodule
`default_nettype wire

// ===== rtl/morph_gradient_3x3_core.sv =====
// Streaming 3x3 morphological external gradient (dilation minus centre).
// Throughput: one pixel word per cycle while out_stall is low; no stall of its own.
// Pipeline: the pixel completing its window passes the line store read, the
//   window shift and the max/subtract output register before its result word.
// Reset: frame size 640x480 (clamped to MAX_*), position row 0 col 0, window
//   zero; line stores are not cleared and need no clearing pass.
`default_nettype none
module morph_gradient_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mg3_pkg::PIX_W-1:0]       in_pixel_value,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [$clog2(MAX_HEIGHT)-1:0]        out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]         out_col,
  output logic [mg3_pkg::PIX_W-1:0]            out_gradient,
  output logic                                 out_frame_last,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mg3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mg3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  // Reset sizes, clamped to the configured maxima
  localparam int W_RST = (640 > MAX_WIDTH)  ? MAX_WIDTH  : 640;
  localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  // ---------------------------------------------------------------------
  // Pipeline control: every stage moves together whenever the output
  // register is empty or being drained.
  // ---------------------------------------------------------------------
  logic advance;
  logic in_accept;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = !advance;
  assign in_accept = in_valid && advance;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Frame size registers, held as (size - 1) after clamping to 3..MAX.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] wlast_r, wlast_nxt;
  logic [ROW_W-1:0] hlast_r, hlast_nxt;
  logic             cfg_wr;
  logic [31:0]      cw_ext, ch_ext, cw_clamp, ch_clamp, cw_m1, ch_m1;

  assign cfg_wr = cfg_valid && cfg_ready;

  always_comb begin
    cw_ext   = 32'(cfg_wdata[mg3_pkg::WIDTH_W-1:0]);
    ch_ext   = 32'(cfg_wdata[mg3_pkg::HEIGHT_W-1:0]);
    cw_clamp = (cw_ext < 32'd3) ? 32'd3 :
               (cw_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cw_ext;
    ch_clamp = (ch_ext < 32'd3) ? 32'd3 :
               (ch_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : ch_ext;
    cw_m1    = cw_clamp - 32'd1;
    ch_m1    = ch_clamp - 32'd1;
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_wr) begin
      unique case (mg3_pkg::cfg_reg_t'(cfg_index))
        mg3_pkg::REG_FRAME_WIDTH:  wlast_nxt = cw_m1[COL_W-1:0];
        mg3_pkg::REG_FRAME_HEIGHT: hlast_nxt = ch_m1[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= COL_W'(W_RST - 1);
      hlast_r <= ROW_W'(H_RST - 1);
    end else begin
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: raster position counters and result tagging.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic             row_end, frame_end, s0_emit;

  assign row_end   = (col_cnt_r == wlast_r);
  assign frame_end = row_end && (row_cnt_r == hlast_r);
  // window complete once two full rows and two columns are in
  assign s0_emit   = (row_cnt_r >= ROW_W'(2)) && (col_cnt_r >= COL_W'(2));

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_wr) begin
      // any register write restarts the frame
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_accept) begin
      if (frame_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
      end else if (row_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store read data lands; stores are rewritten at the same
  // column (a <- new pixel, b <- old a). Within a frame consecutive words never
  // share a column, so the read of the next word never collides with this write.
  // ---------------------------------------------------------------------
  logic                s1_valid_r;
  logic                s1_emit_r;
  logic                s1_last_r;
  mg3_pkg::pix_t       s1_pix_r;
  logic [COL_W-1:0]    s1_addr_r;
  logic [ROW_W-1:0]    s1_row_r;
  logic [COL_W-1:0]    s1_col_r;
  mg3_pkg::pix_t       ls_a_rdata, ls_b_rdata;
  logic                s1_fire;

  assign s1_fire = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_emit_r <= s0_emit;
      s1_last_r <= frame_end;
      s1_pix_r  <= in_pixel_value;
      s1_addr_r <= col_cnt_r;
      s1_row_r  <= row_cnt_r - ROW_W'(1);
      s1_col_r  <= col_cnt_r - COL_W'(1);
    end
  end

  // row directly above
  mg3_ram #(.WIDTH(mg3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (in_accept),
    .raddr (col_cnt_r),
    .rdata (ls_a_rdata)
  );

  // two rows above
  mg3_ram #(.WIDTH(mg3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (ls_a_rdata),
    .re    (in_accept),
    .raddr (col_cnt_r),
    .rdata (ls_b_rdata)
  );

  // ---------------------------------------------------------------------
  // Window: chain of three column cells, newest on the right.
  // ---------------------------------------------------------------------
  mg3_pkg::col_t new_col, col2, col1, col0;
  mg3_pkg::pix_t max2, max1, max0;

  assign new_col = '{top: ls_b_rdata, mid: ls_a_rdata, bot: s1_pix_r};

  mg3_col_cell u_cell2 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_fire),
    .col_in(new_col), .col_out(col2), .col_max(max2)
  );
  mg3_col_cell u_cell1 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_fire),
    .col_in(col2), .col_out(col1), .col_max(max1)
  );
  mg3_col_cell u_cell0 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_fire),
    .col_in(col1), .col_out(col0), .col_max(max0)
  );

  // Stage 2 tag travels beside the window
  logic             s2_emit_r;
  logic             s2_last_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_r <= 1'b0;
    end else if (advance) begin
      s2_emit_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: dilation minus centre into the output register. The max
  // includes the centre so the difference never wraps.
  // ---------------------------------------------------------------------
  mg3_pkg::pix_t max10, win_max, grad;

  assign max10   = (max1 > max0) ? max1 : max0;
  assign win_max = (max2 > max10) ? max2 : max10;
  assign grad    = win_max - col1.mid;

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_emit_r) begin
      out_row        <= s2_row_r;
      out_col        <= s2_col_r;
      out_gradient   <= grad;
      out_frame_last <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
